/* hdl/scd_pkg.sv */
`timescale 1ns / 1ps
package scd_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int RANGE_BITS = 16;

  localparam int RANGE_IN_W = 16;
  localparam int RNG_W = (RANGE_BITS < RANGE_IN_W) ? RANGE_BITS : RANGE_IN_W;
  localparam int IDX_W = $clog2(MAX_POINTS + 1);
  localparam int MUL_W = $clog2(MAX_POINTS);

  localparam int ANG_W = 16;
  localparam int QUAD_SH = ANG_W - 2;
  localparam int HALF_Q = 1 << (ANG_W - 3);

  localparam int CS_W = 16;
  localparam int MAG_W = CS_W - 1;
  localparam int PH_W = CS_W;
  localparam int CW = 18;
  localparam int CORDIC_STEPS = 14;
  localparam int CSTEP_W = $clog2(CORDIC_STEPS);
  localparam int CORDIC_ONE = 19898;

  localparam int SUM_W = 28;
  localparam int DCNT_W = $clog2(SUM_W);
  localparam int CEN_W = 17;
  localparam int SHF_W = 18;
  localparam int PCNT_W = 11;
  localparam int OUT_TDATA_W = 88;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 1'b1;
  localparam logic [CFG_W-1:0] START_ANGLE_RST = 16'hC000;
  localparam logic [CFG_W-1:0] ANGLE_STEP_RST = 16'd64;

  typedef struct packed {
    logic                   done;
    logic signed [CS_W-1:0] cos_v;
    logic signed [CS_W-1:0] sin_v;
  } scd_cs_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] qx;
    logic [SUM_W-1:0] qy;
  } scd_quo_t;

  function automatic logic signed [CW-1:0] cordic_atan(input logic [CSTEP_W-1:0] i);
    logic signed [CW-1:0] v;
    unique case (i)
      4'd0:    v = 18'sd8192;
      4'd1:    v = 18'sd4836;
      4'd2:    v = 18'sd2555;
      4'd3:    v = 18'sd1297;
      4'd4:    v = 18'sd651;
      4'd5:    v = 18'sd326;
      4'd6:    v = 18'sd163;
      4'd7:    v = 18'sd81;
      4'd8:    v = 18'sd41;
      4'd9:    v = 18'sd20;
      4'd10:   v = 18'sd10;
      4'd11:   v = 18'sd5;
      4'd12:   v = 18'sd3;
      4'd13:   v = 18'sd1;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/scd_cordic.sv */
`timescale 1ns / 1ps
module scd_cordic (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [scd_pkg::ANG_W-1:0]   ang,
  output scd_pkg::scd_cs_t            cs
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_MAP} cstate_t;

  cstate_t                         st_r;
  logic [scd_pkg::CSTEP_W-1:0]     i_r;
  logic [1:0]                      q_r;
  logic signed [scd_pkg::CW-1:0]   x_r, y_r, z_r;
  scd_pkg::scd_cs_t                cs_r;

  logic [scd_pkg::ANG_W-1:0]       ap;
  logic [1:0]                      qn;
  logic [scd_pkg::ANG_W-1:0]       zn;
  logic signed [scd_pkg::CW-1:0]   dx, dy, at;
  logic signed [scd_pkg::CS_W-1:0] xc, yc;

  function automatic logic signed [scd_pkg::CS_W-1:0] clamp15(
    input logic signed [scd_pkg::CW-1:0] v);
    logic signed [scd_pkg::CS_W-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sd32767;
    end else if (v < -18'sd32767) begin
      r = -16'sd32767;
    end else begin
      r = v[scd_pkg::CS_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    ap = ang + 16'(scd_pkg::HALF_Q);
    qn = ap[scd_pkg::ANG_W-1:scd_pkg::QUAD_SH];
    zn = ang - {qn, {scd_pkg::QUAD_SH{1'b0}}};
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    at = scd_pkg::cordic_atan(i_r);
    xc = clamp15(x_r);
    yc = clamp15(y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= C_IDLE;
      cs_r.done <= 1'b0;
    end else begin
      cs_r.done <= (st_r == C_MAP);
      unique case (st_r)
        C_IDLE: begin
          if (go) begin
            q_r <= qn;
            z_r <= {{(scd_pkg::CW - scd_pkg::ANG_W){zn[scd_pkg::ANG_W-1]}}, zn};
            x_r <= 18'(scd_pkg::CORDIC_ONE);
            y_r <= '0;
            i_r <= '0;
            st_r <= C_RUN;
          end
        end
        C_RUN: begin
          if (!z_r[scd_pkg::CW-1]) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + at;
          end
          i_r <= i_r + 1'b1;
          if (i_r == scd_pkg::CSTEP_W'(scd_pkg::CORDIC_STEPS - 1)) begin
            st_r <= C_MAP;
          end
        end
        C_MAP: begin
          case (q_r)
            2'd0: begin
              cs_r.cos_v <= xc;
              cs_r.sin_v <= yc;
            end
            2'd1: begin
              cs_r.cos_v <= -yc;
              cs_r.sin_v <= xc;
            end
            2'd2: begin
              cs_r.cos_v <= -xc;
              cs_r.sin_v <= -yc;
            end
            default: begin
              cs_r.cos_v <= yc;
              cs_r.sin_v <= -xc;
            end
          endcase
          st_r <= C_IDLE;
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

  assign cs = cs_r;

endmodule

/* hdl/scd_div.sv */
`timescale 1ns / 1ps
module scd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [scd_pkg::SUM_W-1:0]   num_x,
  input  logic [scd_pkg::SUM_W-1:0]   num_y,
  input  logic [scd_pkg::IDX_W-1:0]   den,
  output scd_pkg::scd_quo_t           quo
);

  logic                            busy_r;
  logic                            done_r;
  logic [scd_pkg::DCNT_W-1:0]      cnt_r;
  logic [scd_pkg::SUM_W-1:0]       nx_r, ny_r;
  logic [scd_pkg::IDX_W:0]         rx_r, ry_r;

  logic [scd_pkg::IDX_W+1:0]       shx, shy, dfx, dfy;

  always_comb begin
    shx = {1'b0, rx_r[scd_pkg::IDX_W-1:0], nx_r[scd_pkg::SUM_W-1]};
    shy = {1'b0, ry_r[scd_pkg::IDX_W-1:0], ny_r[scd_pkg::SUM_W-1]};
    dfx = shx - {2'b00, den};
    dfy = shy - {2'b00, den};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !go && busy_r && (cnt_r == scd_pkg::DCNT_W'(scd_pkg::SUM_W - 1));
      if (go) begin
        nx_r   <= num_x;
        ny_r   <= num_y;
        rx_r   <= '0;
        ry_r   <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!dfx[scd_pkg::IDX_W+1]) begin
          rx_r <= dfx[scd_pkg::IDX_W:0];
          nx_r <= {nx_r[scd_pkg::SUM_W-2:0], 1'b1};
        end else begin
          rx_r <= shx[scd_pkg::IDX_W:0];
          nx_r <= {nx_r[scd_pkg::SUM_W-2:0], 1'b0};
        end
        if (!dfy[scd_pkg::IDX_W+1]) begin
          ry_r <= dfy[scd_pkg::IDX_W:0];
          ny_r <= {ny_r[scd_pkg::SUM_W-2:0], 1'b1};
        end else begin
          ry_r <= shy[scd_pkg::IDX_W:0];
          ny_r <= {ny_r[scd_pkg::SUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == scd_pkg::DCNT_W'(scd_pkg::SUM_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign quo.done = done_r;
  assign quo.qx   = nx_r;
  assign quo.qy   = ny_r;

endmodule

/* hdl/scan_centroid_displacement.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake                   Contents
// in_       request    in_tvalid / in_tready       range, invalid flag, last of scan
// out_      result     out_tvalid / out_tready     centroid, shift, flags, point count
// cfg_      write      cfg_we                      start angle, angle step
//
// A valid sample passes through a bit-serial angle multiply, a 14-step CORDIC, and two
// bit-serial range multiplies. An invalid or surplus sample skips them and is not
// accumulated. The last sample of a scan adds a restoring divide with one quotient bit
// per cycle for both axes; an empty scan skips the divide.
// The input is ready only between samples; a finished result waits in the output
// register, and the next scan can be taken while it waits. Reset is synchronous.
module scan_centroid_displacement (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [scd_pkg::RANGE_IN_W-1:0]      in_tdata,   // range_mm
  input  logic [0:0]                          in_tuser,   // range_invalid
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // centroid_x, centroid_y, shift_x, shift_y, shift_valid, empty_scan, point_count, pad
  output logic [scd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [scd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [scd_pkg::CFG_W-1:0]           cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_ANG, S_QUAD, S_ROT, S_MUL, S_ACC, S_DSET, S_DIV, S_OUT
  } state_t;

  localparam int PROD_W = scd_pkg::PH_W + scd_pkg::RNG_W;
  localparam int TERM_W = PROD_W - scd_pkg::MAG_W;
  localparam int EXT_W = scd_pkg::SUM_W + 1;

  state_t                           state_r;
  logic [scd_pkg::CFG_W-1:0]        start_ang_r, ang_step_r;
  logic [scd_pkg::IDX_W-1:0]        idx_r, vcnt_r;
  logic [scd_pkg::MUL_W-1:0]        idx_sh_r;
  logic [scd_pkg::ANG_W-1:0]        prod_ang_r, ang_r;
  logic [4:0]                       cnt_r;
  logic [scd_pkg::RNG_W-1:0]        rng_r;
  logic                             last_r;
  logic                             cor_go_r, div_go_r;
  logic [scd_pkg::PH_W-1:0]         phx_r, phy_r;
  logic [scd_pkg::RNG_W-1:0]        plx_r, ply_r;
  logic [scd_pkg::MAG_W-1:0]        magx_r, magy_r;
  logic                             negx_r, negy_r;
  logic signed [scd_pkg::SUM_W-1:0] sum_x_r, sum_y_r;
  logic [scd_pkg::SUM_W-1:0]        qx_r, qy_r;
  logic                             sgnx_r, sgny_r;
  logic [scd_pkg::CEN_W-1:0]        prevx_r, prevy_r;
  logic                             prev_present_r;
  logic                             out_tvalid_r;
  logic [scd_pkg::CEN_W-1:0]        ocx_r, ocy_r;
  logic [scd_pkg::SHF_W-1:0]        oshx_r, oshy_r;
  logic                             osv_r, oemp_r;
  logic [scd_pkg::PCNT_W-1:0]       opc_r;

  scd_pkg::scd_cs_t                 cs;
  scd_pkg::scd_quo_t                quo;

  logic                             active;
  logic [scd_pkg::PH_W-1:0]         tx_add, ty_add;
  logic [PROD_W-1:0]                prx, pry;
  logic [EXT_W-1:0]                 termx, termy, sx_nxt, sy_nxt;
  logic [scd_pkg::SUM_W-1:0]        absx, absy;
  logic [scd_pkg::CS_W-1:0]         cmagx, cmagy;
  logic [scd_pkg::CEN_W-1:0]        cenx, ceny;
  logic [scd_pkg::SHF_W-1:0]        shfx, shfy;
  logic                             empty, sv;

  scd_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cor_go_r),
    .ang   (ang_r),
    .cs    (cs)
  );

  scd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go_r),
    .num_x (absx),
    .num_y (absy),
    .den   (vcnt_r),
    .quo   (quo)
  );

  always_comb begin
    active = !in_tuser[0] && (idx_r != scd_pkg::IDX_W'(scd_pkg::MAX_POINTS));
    tx_add = phx_r + {1'b0, magx_r};
    ty_add = phy_r + {1'b0, magy_r};
    prx = {phx_r, plx_r};
    pry = {phy_r, ply_r};
    termx = {{(EXT_W - TERM_W){1'b0}}, prx[PROD_W-1:scd_pkg::MAG_W]};
    termy = {{(EXT_W - TERM_W){1'b0}}, pry[PROD_W-1:scd_pkg::MAG_W]};
    if (negx_r) begin
      termx = -termx;
    end
    if (negy_r) begin
      termy = -termy;
    end
    sx_nxt = {sum_x_r[scd_pkg::SUM_W-1], sum_x_r} + termx;
    sy_nxt = {sum_y_r[scd_pkg::SUM_W-1], sum_y_r} + termy;
    absx = sum_x_r[scd_pkg::SUM_W-1] ? (~sum_x_r + 1'b1) : sum_x_r;
    absy = sum_y_r[scd_pkg::SUM_W-1] ? (~sum_y_r + 1'b1) : sum_y_r;
    cmagx = (qx_r[scd_pkg::SUM_W-1:scd_pkg::CS_W] != '0) ? '1 : qx_r[scd_pkg::CS_W-1:0];
    cmagy = (qy_r[scd_pkg::SUM_W-1:scd_pkg::CS_W] != '0) ? '1 : qy_r[scd_pkg::CS_W-1:0];
    cenx = sgnx_r ? -{1'b0, cmagx} : {1'b0, cmagx};
    ceny = sgny_r ? -{1'b0, cmagy} : {1'b0, cmagy};
    empty = (vcnt_r == '0);
    sv = !empty && prev_present_r;
    shfx = {cenx[scd_pkg::CEN_W-1], cenx} - {prevx_r[scd_pkg::CEN_W-1], prevx_r};
    shfy = {ceny[scd_pkg::CEN_W-1], ceny} - {prevy_r[scd_pkg::CEN_W-1], prevy_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      start_ang_r    <= scd_pkg::START_ANGLE_RST;
      ang_step_r     <= scd_pkg::ANGLE_STEP_RST;
      idx_r          <= '0;
      vcnt_r         <= '0;
      sum_x_r        <= '0;
      sum_y_r        <= '0;
      prevx_r        <= '0;
      prevy_r        <= '0;
      prev_present_r <= 1'b0;
      out_tvalid_r   <= 1'b0;
      cor_go_r       <= 1'b0;
      div_go_r       <= 1'b0;
    end else begin
      cor_go_r <= (state_r == S_QUAD);
      div_go_r <= (state_r == S_DSET) && (vcnt_r != '0);
      if (cfg_we) begin
        unique case (cfg_index)
          scd_pkg::REG_START_ANGLE: start_ang_r <= cfg_wdata;
          scd_pkg::REG_ANGLE_STEP:  ang_step_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid_r && out_tready && state_r != S_OUT) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            rng_r      <= in_tdata[scd_pkg::RNG_W-1:0];
            last_r     <= in_tlast;
            idx_sh_r   <= idx_r[scd_pkg::MUL_W-1:0];
            prod_ang_r <= '0;
            cnt_r      <= '0;
            if (idx_r != scd_pkg::IDX_W'(scd_pkg::MAX_POINTS)) begin
              idx_r <= idx_r + 1'b1;
            end
            if (active) begin
              vcnt_r  <= vcnt_r + 1'b1;
              state_r <= S_ANG;
            end else if (in_tlast) begin
              state_r <= S_DSET;
            end
          end
        end
        S_ANG: begin
          prod_ang_r <= {prod_ang_r[scd_pkg::ANG_W-2:0], 1'b0}
                        + (idx_sh_r[scd_pkg::MUL_W-1] ? ang_step_r : '0);
          idx_sh_r <= {idx_sh_r[scd_pkg::MUL_W-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'(scd_pkg::MUL_W - 1)) begin
            state_r <= S_QUAD;
          end
        end
        S_QUAD: begin
          ang_r    <= start_ang_r + prod_ang_r;
          state_r  <= S_ROT;
        end
        S_ROT: begin
          if (cs.done) begin
            magx_r  <= scd_pkg::MAG_W'(cs.cos_v[scd_pkg::CS_W-1] ? -cs.cos_v : cs.cos_v);
            magy_r  <= scd_pkg::MAG_W'(cs.sin_v[scd_pkg::CS_W-1] ? -cs.sin_v : cs.sin_v);
            negx_r  <= cs.cos_v[scd_pkg::CS_W-1];
            negy_r  <= cs.sin_v[scd_pkg::CS_W-1];
            phx_r   <= '0;
            phy_r   <= '0;
            plx_r   <= rng_r;
            ply_r   <= rng_r;
            cnt_r   <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          {phx_r, plx_r} <= {(plx_r[0] ? tx_add : phx_r), plx_r} >> 1;
          {phy_r, ply_r} <= {(ply_r[0] ? ty_add : phy_r), ply_r} >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'(scd_pkg::RNG_W - 1)) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (sx_nxt[EXT_W-1] != sx_nxt[EXT_W-2]) begin
            sum_x_r <= sx_nxt[EXT_W-1] ? {1'b1, {(scd_pkg::SUM_W-1){1'b0}}}
                                       : {1'b0, {(scd_pkg::SUM_W-1){1'b1}}};
          end else begin
            sum_x_r <= sx_nxt[scd_pkg::SUM_W-1:0];
          end
          if (sy_nxt[EXT_W-1] != sy_nxt[EXT_W-2]) begin
            sum_y_r <= sy_nxt[EXT_W-1] ? {1'b1, {(scd_pkg::SUM_W-1){1'b0}}}
                                       : {1'b0, {(scd_pkg::SUM_W-1){1'b1}}};
          end else begin
            sum_y_r <= sy_nxt[scd_pkg::SUM_W-1:0];
          end
          state_r <= last_r ? S_DSET : S_IDLE;
        end
        S_DSET: begin
          sgnx_r <= sum_x_r[scd_pkg::SUM_W-1];
          sgny_r <= sum_y_r[scd_pkg::SUM_W-1];
          if (vcnt_r == '0) begin
            qx_r    <= '0;
            qy_r    <= '0;
            state_r <= S_OUT;
          end else begin
            state_r  <= S_DIV;
          end
        end
        S_DIV: begin
          if (quo.done) begin
            qx_r    <= quo.qx;
            qy_r    <= quo.qy;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            ocx_r          <= cenx;
            ocy_r          <= ceny;
            oshx_r         <= sv ? shfx : '0;
            oshy_r         <= sv ? shfy : '0;
            osv_r          <= sv;
            oemp_r         <= empty;
            opc_r          <= scd_pkg::PCNT_W'(vcnt_r);
            out_tvalid_r   <= 1'b1;
            prevx_r        <= cenx;
            prevy_r        <= ceny;
            prev_present_r <= !empty;
            sum_x_r        <= '0;
            sum_y_r        <= '0;
            vcnt_r         <= '0;
            idx_r          <= '0;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(scd_pkg::OUT_TDATA_W - 2 * scd_pkg::CEN_W - 2 * scd_pkg::SHF_W
                        - 2 - scd_pkg::PCNT_W){1'b0}},
                       opc_r, oemp_r, osv_r, oshy_r, oshx_r, ocy_r, ocx_r};

  a_empty_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && oemp_r) |-> (opc_r == '0 && !osv_r && oshx_r == '0))
    else $error("empty scan result carries points or a shift");

  a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
    cs.done |-> (state_r == S_ROT))
    else $error("rotation result arrived outside the rotation wait");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    quo.done |-> (state_r == S_DIV))
    else $error("quotient arrived outside the divide wait");

  a_count_le_index: assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r <= idx_r)
    else $error("valid point count exceeds sample index");

  a_scan_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_tvalid_r || out_tready))
    |=> (out_tvalid_r && vcnt_r == '0 && idx_r == '0 && in_tready))
    else $error("scan end did not publish a result and clear the accumulators");

endmodule
